// ----- sv/xalu_pkg.sv -----
// shared codes, command and status types, and helpers for the x86 alu
package xalu_pkg;

	localparam logic [4:0] OP_ADD  = 5'd0;
	localparam logic [4:0] OP_ADC  = 5'd1;
	localparam logic [4:0] OP_SUB  = 5'd2;
	localparam logic [4:0] OP_SBB  = 5'd3;
	localparam logic [4:0] OP_AND  = 5'd4;
	localparam logic [4:0] OP_OR   = 5'd5;
	localparam logic [4:0] OP_XOR  = 5'd6;
	localparam logic [4:0] OP_SHL  = 5'd7;
	localparam logic [4:0] OP_SAL  = 5'd8;
	localparam logic [4:0] OP_SHR  = 5'd9;
	localparam logic [4:0] OP_SAR  = 5'd10;
	localparam logic [4:0] OP_MUL  = 5'd11;
	localparam logic [4:0] OP_IMUL = 5'd12;
	localparam logic [4:0] OP_DIV  = 5'd13;
	localparam logic [4:0] OP_IDIV = 5'd14;
	localparam logic [4:0] OP_MOD  = 5'd15;
	localparam logic [4:0] OP_IMOD = 5'd16;

	localparam logic [1:0] SZ_8  = 2'd0;
	localparam logic [1:0] SZ_16 = 2'd1;

	localparam int DIV_STEPS = 64;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic load;
		logic mul_done;
		logic div_step;
		logic div_done;
	} xalu_cmd_t;

	typedef struct packed {
		logic is_mul;
		logic is_div;
		logic out_free;
	} xalu_stat_t;

	function automatic logic [31:0] size_mask(input logic [1:0] sz);
		case (sz)
			SZ_8:    size_mask = 32'h0000_00FF;
			SZ_16:   size_mask = 32'h0000_FFFF;
			default: size_mask = 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic top_bit(input logic [31:0] x, input logic [1:0] sz);
		case (sz)
			SZ_8:    top_bit = x[7];
			SZ_16:   top_bit = x[15];
			default: top_bit = x[31];
		endcase
	endfunction

	function automatic logic carry_bit(input logic [32:0] x, input logic [1:0] sz);
		case (sz)
			SZ_8:    carry_bit = x[8];
			SZ_16:   carry_bit = x[16];
			default: carry_bit = x[32];
		endcase
	endfunction

	function automatic logic [31:0] sext32(input logic [31:0] x, input logic [1:0] sz);
		case (sz)
			SZ_8:    sext32 = {{24{x[7]}}, x[7:0]};
			SZ_16:   sext32 = {{16{x[15]}}, x[15:0]};
			default: sext32 = x;
		endcase
	endfunction

endpackage

// ----- sv/xalu_ctrl.sv -----
// controller state machine sequencing directly committed, multiply and divide operations
module xalu_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  xalu_pkg::xalu_stat_t stat,
	output xalu_pkg::xalu_cmd_t  cmd
);
	import xalu_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_MFIN, S_DIV, S_DFIN} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;

	assign in_ready     = (state_q == S_IDLE) && stat.out_free;
	assign cmd.load     = in_valid && in_ready;
	assign cmd.mul_done = (state_q == S_MFIN) && stat.out_free;
	assign cmd.div_step = (state_q == S_DIV);
	assign cmd.div_done = (state_q == S_DFIN) && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load && stat.is_mul) begin
						state_q <= S_MUL;
					end else if (cmd.load && stat.is_div) begin
						state_q <= S_DIV;
						cnt_q   <= '0;
					end
				end
				S_MUL: state_q <= S_MFIN;
				S_MFIN: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= S_DFIN;
				end
				S_DFIN: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/xalu_dp.sv -----
// datapath: combinational alu, registered multiplier, radix-2 divider, flags and output register
module xalu_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  xalu_pkg::xalu_cmd_t  cmd,
	output xalu_pkg::xalu_stat_t stat,
	input  logic [4:0]           mode,
	input  logic [1:0]           operand_size,
	input  logic [31:0]          source_value,
	input  logic [63:0]          dest_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [71:0]          out_data
);
	import xalu_pkg::*;

	logic [31:0] m, a, b, sx_src, sx_dst;
	logic [4:0]  cnt, cntm1;
	logic        cin, bin, dz, is_divop, is_sgn_div;
	logic [32:0] sum, diff;
	logic [63:0] shl_w;
	logic [31:0] shr_t, sar_t;
	logic [31:0] n_res;
	logic        n_cf, n_of, n_derr, upd_cf, upd_of, upd_szp;
	logic        commit1;

	// flags and output
	logic        cf_q, pf_q, zf_q, sf_q, of_q, derr_q, valid_q;
	logic [63:0] res_q;

	// multiply
	logic [4:0]         mode_q;
	logic [1:0]         size_q;
	logic signed [32:0] opa_q, opb_q;
	logic signed [65:0] prod_full;
	logic [63:0]        prod_q;
	logic [31:0]        mq, psx;
	logic               mul_ovf;

	// divide
	logic [63:0] quo_q;
	logic [31:0] rem_q, dvs_q;
	logic        nd_q, ns_q;
	logic [32:0] t_div;
	logic        ge;
	logic [63:0] qn, rn, dsel;
	logic        ns_in;
	logic [31:0] us_in;

	assign m          = size_mask(operand_size);
	assign a          = source_value & m;
	assign b          = dest_value[31:0] & m;
	assign sx_src     = sext32(source_value, operand_size);
	assign sx_dst     = sext32(dest_value[31:0], operand_size);
	assign cnt        = source_value[4:0];
	assign cntm1      = cnt - 5'd1;
	assign cin        = (mode == OP_ADC) && cf_q;
	assign bin        = (mode == OP_SBB) && cf_q;
	assign sum        = {1'b0, a} + {1'b0, b} + {32'b0, cin};
	assign diff       = {1'b0, b} - {1'b0, a} - {32'b0, bin};
	assign shl_w      = {32'b0, b} << cnt;
	assign shr_t      = b >> cntm1;
	assign sar_t      = sx_dst >> cntm1;
	assign dz         = (a == 32'd0);
	assign is_divop   = (mode == OP_DIV) || (mode == OP_IDIV) || (mode == OP_MOD)
		|| (mode == OP_IMOD);
	assign is_sgn_div = (mode == OP_IDIV) || (mode == OP_IMOD);

	assign stat.is_mul   = (mode == OP_MUL) || (mode == OP_IMUL);
	assign stat.is_div   = is_divop && !dz;
	assign stat.out_free = !valid_q || out_ready;

	always_comb begin
		n_res   = '0;
		n_cf    = 1'b0;
		n_of    = 1'b0;
		n_derr  = 1'b0;
		upd_cf  = 1'b0;
		upd_of  = 1'b0;
		upd_szp = 1'b0;
		case (mode)
			OP_ADD, OP_ADC: begin
				n_res   = sum[31:0] & m;
				n_cf    = carry_bit(sum, operand_size);
				n_of    = top_bit((a ^ n_res) & (b ^ n_res), operand_size);
				upd_cf  = 1'b1;
				upd_of  = 1'b1;
				upd_szp = 1'b1;
			end
			OP_SUB, OP_SBB: begin
				n_res   = diff[31:0] & m;
				n_cf    = ({1'b0, a} + {32'b0, bin}) > {1'b0, b};
				n_of    = top_bit((b ^ a) & (b ^ n_res), operand_size);
				upd_cf  = 1'b1;
				upd_of  = 1'b1;
				upd_szp = 1'b1;
			end
			OP_AND, OP_OR, OP_XOR: begin
				case (mode)
					OP_AND:  n_res = a & b;
					OP_OR:   n_res = a | b;
					default: n_res = a ^ b;
				endcase
				upd_cf  = 1'b1;
				upd_of  = 1'b1;
				upd_szp = 1'b1;
			end
			OP_SHL, OP_SAL: begin
				if (cnt == 5'd0) begin
					n_res = b;
				end else begin
					n_res   = shl_w[31:0] & m;
					n_cf    = carry_bit(shl_w[32:0], operand_size);
					upd_cf  = 1'b1;
					upd_szp = 1'b1;
				end
			end
			OP_SHR: begin
				if (cnt == 5'd0) begin
					n_res = b;
				end else begin
					n_res   = b >> cnt;
					n_cf    = shr_t[0];
					upd_cf  = 1'b1;
					upd_szp = 1'b1;
				end
			end
			OP_SAR: begin
				if (cnt == 5'd0) begin
					n_res = b;
				end else begin
					n_res   = 32'($signed(sx_dst) >>> cnt) & m;
					n_cf    = sar_t[0];
					upd_cf  = 1'b1;
					upd_szp = 1'b1;
				end
			end
			OP_DIV, OP_IDIV, OP_MOD, OP_IMOD: n_derr = dz;
			default: n_res = '0;
		endcase
	end

	assign commit1 = cmd.load && !stat.is_mul && !stat.is_div;

	// multiply overflow from the registered product
	assign prod_full = opa_q * opb_q;
	assign mq        = size_mask(size_q);
	assign psx       = sext32(prod_q[31:0], size_q);
	assign mul_ovf   = (mode_q == OP_MUL) ? ((prod_q & ~{32'b0, mq}) != 64'd0)
		: ({{32{psx[31]}}, psx} != prod_q);

	// divider operand setup and step
	assign ns_in = is_sgn_div && sx_src[31];
	assign us_in = ns_in ? (32'd0 - sx_src) : (is_sgn_div ? sx_src : a);
	assign t_div = {rem_q, quo_q[63]};
	assign ge    = t_div >= {1'b0, dvs_q};
	assign qn    = (nd_q ^ ns_q) ? (64'd0 - quo_q) : quo_q;
	assign rn    = nd_q ? (64'd0 - {32'b0, rem_q}) : {32'b0, rem_q};
	assign dsel  = ((mode_q == OP_DIV) || (mode_q == OP_IDIV)) ? qn : rn;

	always_ff @(posedge clk) begin
		prod_q <= prod_full[63:0];
		if (cmd.load) begin
			mode_q <= mode;
			size_q <= operand_size;
			opa_q  <= (mode == OP_IMUL) ? {sx_src[31], sx_src} : {1'b0, a};
			opb_q  <= (mode == OP_IMUL) ? {sx_dst[31], sx_dst} : {1'b0, b};
			nd_q   <= is_sgn_div && dest_value[63];
			ns_q   <= ns_in;
			dvs_q  <= us_in;
			quo_q  <= (is_sgn_div && dest_value[63]) ? (64'd0 - dest_value) : dest_value;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? 32'(t_div - {1'b0, dvs_q}) : t_div[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
		if (commit1) begin
			res_q  <= {32'b0, n_res};
			derr_q <= n_derr;
		end else if (cmd.mul_done) begin
			res_q  <= prod_q;
			derr_q <= 1'b0;
		end else if (cmd.div_done) begin
			res_q  <= {32'b0, dsel[31:0] & mq};
			derr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cf_q    <= 1'b0;
			pf_q    <= 1'b0;
			zf_q    <= 1'b0;
			sf_q    <= 1'b0;
			of_q    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (commit1) begin
				if (upd_cf) cf_q <= n_cf;
				if (upd_of) of_q <= n_of;
				if (upd_szp) begin
					pf_q <= ~^n_res[7:0];
					zf_q <= (n_res == 32'd0);
					sf_q <= top_bit(n_res, operand_size);
				end
			end else if (cmd.mul_done) begin
				cf_q <= mul_ovf;
				of_q <= mul_ovf;
			end
			if (commit1 || cmd.mul_done || cmd.div_done) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = {2'b00, derr_q, of_q, sf_q, zf_q, pf_q, cf_q, res_q};

endmodule

// ----- sv/x86_integer_alu_with_flags_unit.sv -----
// top level: x86 integer alu with flags, stream request in and result out
// add/sub/logic/shift, unused modes and zero-divisor divides: result registered on accept
// mul and imul: operand register, then 33x33 multiplier register, then flag commit
// div, idiv, mod, imod: one-bit-per-cycle restoring divider (64 steps), then result commit
// throughput: one request in flight; the next is taken once the output register is free
// reset: arst_n clears the flags, the controller and the output valid; payload is not reset
module x86_integer_alu_with_flags_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [4:0] mode, [6:5] operand_size, [38:7] source_value, [102:39] dest_value, [103] zero
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [63:0] result_value, [64] carry_out, [65] parity_out, [66] zero_out,
	// [67] sign_out, [68] overflow_out, [69] divide_error, [71:70] zero
	output logic [71:0]  m_tdata
);
	import xalu_pkg::*;

	xalu_cmd_t  cmd;
	xalu_stat_t stat;

	// controller owns sequencing; datapath owns all arithmetic and flag state
	xalu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// request fields unpacked straight from the bus
	xalu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (s_tdata[4:0]),
		.operand_size (s_tdata[6:5]),
		.source_value (s_tdata[38:7]),
		.dest_value   (s_tdata[102:39]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_data     (m_tdata)
	);

endmodule
